@@ rtl/gtmn_pkg.sv @@
// package for the gesture triggered min/max normalizer
// types, codes and reset constants shared by the front end, queue, back end and top level
// no dependencies
package gtmn_pkg;

    localparam int DEF_CHANNELS    = 16;
    localparam int DEF_SAMPLE_BITS = 12;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [14:0] SWING_RESET = 15'd350;
    localparam logic [19:0] WAIT_RESET  = 20'd500000;
    localparam logic [19:0] CALIB_RESET = 20'd800000;
    localparam logic [19:0] TICK_MAX    = 20'hFFFFF;
    localparam logic [6:0]  PCT_FULL    = 7'd100;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_ACCEL  = 2'd2,
        OP_LOAD   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_WAIT = 2'd0,
        MODE_CAL  = 2'd1,
        MODE_RUN  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CFG_SWING = 2'd0,
        CFG_WAIT  = 2'd1,
        CFG_CALIB = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_MUL,
        BK_DIV,
        BK_FINISH
    } bk_state_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [3:0]         channel;
        logic [11:0]        sample;
        logic signed [15:0] accel;
        logic               bound_select;
    } in_t;

    typedef struct packed {
        logic [6:0]  percent;
        logic [1:0]  mode;
        logic [11:0] low_bound;
        logic [11:0] high_bound;
        logic        calibration_done;
    } out_t;

    // classified item as it travels from front to back
    typedef struct packed {
        op_t                op;
        logic [3:0]         channel;
        logic               ch_ok;
        logic [11:0]        sample;
        logic signed [15:0] accel;
        logic               bound_select;
    } item_t;

endpackage

@@ rtl/gtmn_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module gtmn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

@@ rtl/gtmn_front.sv @@
// front end: takes input items and classifies them for the back end
// depends on gtmn_pkg
module gtmn_front #(
    parameter int CHANNELS    = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  logic           s_valid,
    output logic           s_ready,
    input  gtmn_pkg::in_t  s_data,
    input  logic           q_full,
    output logic           q_push,
    output gtmn_pkg::item_t q_item
);
    import gtmn_pkg::*;

    localparam logic [11:0] SMASK =
        (SAMPLE_BITS >= 12) ? 12'hFFF : 12'((1 << SAMPLE_BITS) - 1);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_item.op           = op_t'(s_data.op);
        q_item.channel      = s_data.channel;
        q_item.ch_ok        = 32'(s_data.channel) < CHANNELS;
        q_item.sample       = s_data.sample & SMASK;
        q_item.accel        = s_data.accel;
        q_item.bound_select = s_data.bound_select;
    end

endmodule

@@ rtl/gtmn_fifo.sv @@
// short queue of classified items between front and back end
// depends on gtmn_pkg
module gtmn_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  gtmn_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output gtmn_pkg::item_t head,
    output logic            empty
);
    import gtmn_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    item_t         slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [PW:0]   cnt_reg, cnt_next;

    assign full  = cnt_reg == (PW+1)'(QUEUE_DEPTH);
    assign empty = cnt_reg == '0;
    assign head  = slot_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push) begin
            wptr_next = (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/gtmn_back.sv @@
// back end: mode sequencer, bound store, shift-subtract percent divider, output register
// depends on gtmn_pkg and gtmn_ram
module gtmn_back #(
    parameter int CHANNELS    = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_valid,
    input  logic [1:0]      cfg_index,
    input  logic [19:0]     cfg_data,
    input  logic            q_empty,
    input  gtmn_pkg::item_t q_head,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output gtmn_pkg::out_t  m_data
);
    import gtmn_pkg::*;

    localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SB    = SAMPLE_BITS;
    localparam int MAG_W = SAMPLE_BITS + 7;

    // configuration
    logic [14:0] swing_reg;
    logic [19:0] wait_to_reg;
    logic [19:0] calib_reg;

    // control state
    bk_state_t          state_reg, state_next;
    mode_t              mode_reg;
    logic [19:0]        tick_reg;
    logic [CHANNELS-1:0] seen_reg;
    logic [CHANNELS-1:0] bvalid_reg;
    logic signed [15:0] base_reg, amin_reg, amax_reg;
    logic               base_ok_reg;
    logic               m_valid_reg;

    // item and datapath
    item_t              item_reg;
    logic [SB-1:0]      lo_reg, hi_reg;
    logic [SB-1:0]      num_mag_reg, den_mag_reg;
    logic [MAG_W-1:0]   a_reg, c_reg, bsh_reg;
    logic [2:0]         cnt_reg;
    logic [6:0]         q_reg;
    logic [6:0]         pct_reg;
    logic               done_reg;
    out_t               out_reg;

    // control outputs
    logic ram_re, ram_we, out_load, out_free;

    // exec stage values
    logic [AW-1:0]      addr;
    logic [2*SB-1:0]    rd_data;
    logic [SB-1:0]      v, cur_lo, cur_hi, new_lo, new_hi;
    logic signed [SB:0] num, den;
    logic               num_neg, den_neg, div_go;
    logic [6:0]         pct_fixed;
    logic [19:0]        tick_inc;
    logic signed [15:0] nmin, nmax;
    logic signed [17:0] thr_lo, thr_hi;
    logic               swing;
    logic               clamp, step_ge;

    assign addr     = AW'(item_reg.channel);
    assign v        = SB'(item_reg.sample);
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

    gtmn_ram #(
        .WIDTH (2*SB),
        .DEPTH (CHANNELS)
    ) u_bounds (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr),
        .wdata ({new_hi, new_lo}),
        .re    (ram_re),
        .raddr (AW'(q_head.channel)),
        .rdata (rd_data)
    );

    // bound update and percent setup
    always_comb begin
        cur_lo = bvalid_reg[addr] ? rd_data[SB-1:0]    : '0;
        cur_hi = bvalid_reg[addr] ? rd_data[2*SB-1:SB] : '0;
        new_lo = cur_lo;
        new_hi = cur_hi;
        if (item_reg.op == OP_SAMPLE && mode_reg == MODE_CAL) begin
            if (!seen_reg[addr]) begin
                new_lo = v;
                new_hi = v;
            end else begin
                if (v < cur_lo) new_lo = v;
                if (v > cur_hi) new_hi = v;
            end
        end else if (item_reg.op == OP_LOAD) begin
            if (item_reg.bound_select) begin
                new_hi = v;
            end else begin
                new_lo = v;
            end
        end
        num     = $signed({1'b0, v}) - $signed({1'b0, new_lo});
        den     = $signed({1'b0, new_hi}) - $signed({1'b0, new_lo});
        num_neg = num[SB];
        den_neg = den[SB];
        // only same-sign nonzero operands need the divider
        div_go  = item_reg.op == OP_SAMPLE && item_reg.ch_ok && num != '0 && den != '0
                  && num_neg == den_neg;
        if (item_reg.op == OP_SAMPLE && item_reg.ch_ok && den == '0) begin
            pct_fixed = PCT_FULL;
        end else begin
            pct_fixed = '0;
        end
    end

    // mode sequencer values
    always_comb begin
        tick_inc = (tick_reg != TICK_MAX) ? tick_reg + 20'd1 : tick_reg;
        nmin     = (item_reg.accel < amin_reg) ? item_reg.accel : amin_reg;
        nmax     = (item_reg.accel > amax_reg) ? item_reg.accel : amax_reg;
        thr_lo   = 18'(base_reg) - $signed({3'b000, swing_reg});
        thr_hi   = 18'(base_reg) + $signed({3'b000, swing_reg});
        swing    = 18'(nmin) < thr_lo && 18'(nmax) > thr_hi;
    end

    // divider step
    always_comb begin
        clamp   = cnt_reg == 3'd6 && a_reg >= c_reg;
        step_ge = a_reg >= bsh_reg;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty) state_next = BK_EXEC;
            end
            BK_EXEC: begin
                state_next = div_go ? BK_MUL : BK_FINISH;
            end
            BK_MUL: begin
                state_next = BK_DIV;
            end
            BK_DIV: begin
                if (clamp || cnt_reg == 3'd0) state_next = BK_FINISH;
            end
            BK_FINISH: begin
                if (out_free) state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        q_pop    = 1'b0;
        ram_re   = 1'b0;
        ram_we   = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                q_pop  = !q_empty;
                ram_re = !q_empty;
            end
            BK_EXEC: begin
                ram_we = item_reg.ch_ok && (item_reg.op == OP_LOAD ||
                         (item_reg.op == OP_SAMPLE && mode_reg == MODE_CAL));
            end
            BK_FINISH: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            mode_reg    <= MODE_WAIT;
            tick_reg    <= '0;
            seen_reg    <= '0;
            bvalid_reg  <= '0;
            base_reg    <= '0;
            amin_reg    <= '0;
            amax_reg    <= '0;
            base_ok_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            swing_reg   <= SWING_RESET;
            wait_to_reg <= WAIT_RESET;
            calib_reg   <= CALIB_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_SWING: swing_reg   <= cfg_data[14:0];
                    CFG_WAIT:  wait_to_reg <= cfg_data;
                    CFG_CALIB: calib_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (ram_we) begin
                bvalid_reg[addr] <= 1'b1;
                if (item_reg.op == OP_SAMPLE) seen_reg[addr] <= 1'b1;
            end
            if (state_reg == BK_EXEC) begin
                unique case (item_reg.op)
                    OP_TICK: begin
                        if (mode_reg == MODE_WAIT) begin
                            tick_reg <= tick_inc;
                            if (tick_inc > wait_to_reg) mode_reg <= MODE_RUN;
                        end else if (mode_reg == MODE_CAL) begin
                            tick_reg <= tick_inc;
                            if (tick_inc >= calib_reg) mode_reg <= MODE_RUN;
                        end
                    end
                    OP_ACCEL: begin
                        if (mode_reg == MODE_WAIT) begin
                            if (!base_ok_reg) begin
                                base_reg    <= item_reg.accel;
                                amin_reg    <= item_reg.accel;
                                amax_reg    <= item_reg.accel;
                                base_ok_reg <= 1'b1;
                            end else begin
                                amin_reg <= nmin;
                                amax_reg <= nmax;
                                if (swing) begin
                                    mode_reg <= MODE_CAL;
                                    tick_reg <= '0;
                                    seen_reg <= '0;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_head;
        end
        unique case (state_reg)
            BK_EXEC: begin
                lo_reg      <= new_lo;
                hi_reg      <= new_hi;
                num_mag_reg <= num_neg ? SB'(-num) : SB'(num);
                den_mag_reg <= den_neg ? SB'(-den) : SB'(den);
                pct_reg     <= pct_fixed;
                done_reg    <= item_reg.op == OP_TICK && mode_reg == MODE_CAL
                               && tick_inc >= calib_reg;
            end
            BK_MUL: begin
                a_reg   <= MAG_W'(num_mag_reg) * MAG_W'(100);
                c_reg   <= MAG_W'(den_mag_reg) * MAG_W'(100);
                bsh_reg <= MAG_W'(den_mag_reg) << 6;
                cnt_reg <= 3'd6;
                q_reg   <= '0;
            end
            BK_DIV: begin
                if (clamp) begin
                    pct_reg <= PCT_FULL;
                end else begin
                    if (step_ge) a_reg <= a_reg - bsh_reg;
                    bsh_reg <= bsh_reg >> 1;
                    q_reg   <= {q_reg[5:0], step_ge};
                    cnt_reg <= cnt_reg - 3'd1;
                    if (cnt_reg == 3'd0) pct_reg <= {q_reg[5:0], step_ge};
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            out_reg.percent          <= pct_reg;
            out_reg.mode             <= mode_reg;
            out_reg.low_bound        <= item_reg.ch_ok ? 12'(lo_reg) : 12'd0;
            out_reg.high_bound       <= item_reg.ch_ok ? 12'(hi_reg) : 12'd0;
            out_reg.calibration_done <= done_reg;
        end
    end

endmodule

@@ rtl/gesture_triggered_minmax_normalizer.sv @@
// Gesture triggered min/max normalizer, top level.
// Depends on gtmn_pkg, gtmn_front, gtmn_fifo, gtmn_back (and gtmn_ram below it).
//
// Input channel s_valid/s_ready/s_data carries one item: an adc sample, a tick,
// an accel sample or a bound load. Every item gives exactly one result item on
// m_valid/m_ready/m_data: percent of the sample between the channel's bounds,
// the mode after the item, the channel's bounds and the end-of-calibration flag.
// Configuration writes go on cfg_valid/cfg_index/cfg_data (cfg_ready is always
// high); the user must make them only while the block is idle, which the block
// itself does not enforce. A two-entry queue sits between the front end and the
// back end, and the back end has its own output register, so input keeps flowing
// while a result waits. The back end takes each item through bound read, update
// and output; a sample that divides also goes through scale by 100 and seven
// shift-subtract steps, stopping after the first when the quotient clamps at 100.
// The back end handles one item at a time: it pops the next item from the queue
// only after the last result is loaded into the output register.
// Reset (aresetn low, synchronous) clears mode, counters, accel tracking and the
// bound valid bits, so every bound reads zero; configuration returns to defaults.
// If m_ready stays low the result holds, the back end stops at its output step,
// the queue fills and s_ready drops.
module gesture_triggered_minmax_normalizer #(
    parameter int CHANNELS    = gtmn_pkg::DEF_CHANNELS,
    parameter int SAMPLE_BITS = gtmn_pkg::DEF_SAMPLE_BITS
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  gtmn_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output gtmn_pkg::out_t m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [19:0]    cfg_data
);
    import gtmn_pkg::*;

    item_t front_item;
    item_t q_head;
    logic  q_push, q_full, q_pop, q_empty;

    assign cfg_ready = 1'b1;

    gtmn_front #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (front_item)
    );

    gtmn_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    gtmn_back #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for gesture_triggered_minmax_normalizer
// holds its own model of the block in a small scoreboard class; needs gtmn_pkg and the rtl
// walks the block through waiting, swing detection, calibration and running with random stalls
module testbench;
    import gtmn_pkg::*;

    localparam int ITEMS  = 1950;
    localparam int SETTLE = 12;
    localparam int LIMIT  = 2000000;

    class percent_scoreboard;
        int        swing_thr;
        int        wait_limit;
        int        cal_len;
        mode_t     mode;
        int        ticks;
        int        lo_b[16];
        int        hi_b[16];
        bit [15:0] seen;
        int        base;
        int        amin;
        int        amax;
        bit        base_ok;
        out_t      expected_q[$];
        int        errors;

        function new();
            swing_thr  = int'(SWING_RESET);
            wait_limit = int'(WAIT_RESET);
            cal_len    = int'(CALIB_RESET);
            mode       = MODE_WAIT;
            ticks      = 0;
            seen       = '0;
            base_ok    = 1'b0;
            errors     = 0;
            foreach (lo_b[i]) begin
                lo_b[i] = 0;
                hi_b[i] = 0;
            end
        endfunction

        function void write_reg(cfg_idx_t idx, logic [19:0] val);
            unique case (idx)
                CFG_SWING: swing_thr  = int'(val[14:0]);
                CFG_WAIT:  wait_limit = int'(val);
                CFG_CALIB: cal_len    = int'(val);
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // signed quotient truncated toward zero, then clamped
        function int scale(int v, int lo, int hi);
            int q;
            if (hi == lo) return int'(PCT_FULL);
            q = (v - lo) * int'(PCT_FULL) / (hi - lo);
            if (q > int'(PCT_FULL)) q = int'(PCT_FULL);
            if (q < 0) q = 0;
            return q;
        endfunction

        function void note_item(in_t it);
            out_t exp;
            int   ch;
            int   v;
            int   acc;
            exp = '0;
            ch  = int'(it.channel);
            v   = int'(it.sample);
            acc = int'(it.accel);
            unique case (it.op)
                OP_SAMPLE: begin
                    if (mode == MODE_CAL) begin
                        if (!seen[ch]) begin
                            lo_b[ch] = v;
                            hi_b[ch] = v;
                            seen[ch] = 1'b1;
                        end else begin
                            if (v < lo_b[ch]) lo_b[ch] = v;
                            if (v > hi_b[ch]) hi_b[ch] = v;
                        end
                    end
                    exp.percent = 7'(scale(v, lo_b[ch], hi_b[ch]));
                end
                OP_TICK: begin
                    if (mode == MODE_WAIT) begin
                        if (ticks < int'(TICK_MAX)) ticks++;
                        if (ticks > wait_limit) mode = MODE_RUN;
                    end else if (mode == MODE_CAL) begin
                        if (ticks < int'(TICK_MAX)) ticks++;
                        if (ticks >= cal_len) begin
                            mode = MODE_RUN;
                            exp.calibration_done = 1'b1;
                        end
                    end
                end
                OP_ACCEL: begin
                    if (mode == MODE_WAIT) begin
                        if (!base_ok) begin
                            base    = acc;
                            amin    = acc;
                            amax    = acc;
                            base_ok = 1'b1;
                        end else begin
                            if (acc < amin) amin = acc;
                            if (acc > amax) amax = acc;
                            if (amin < base - swing_thr && amax > base + swing_thr) begin
                                mode  = MODE_CAL;
                                ticks = 0;
                                seen  = '0;
                            end
                        end
                    end
                end
                default: begin
                    if (it.bound_select) hi_b[ch] = v;
                    else lo_b[ch] = v;
                end
            endcase
            exp.mode       = mode;
            exp.low_bound  = 12'(lo_b[ch]);
            exp.high_bound = 12'(hi_b[ch]);
            expected_q.push_back(exp);
        endfunction

        function void report(string field, int e, int g);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, e, g);
        endfunction

        function void check_result(out_t got);
            out_t exp;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with no item waiting, actual %h", $time, got);
                return;
            end
            exp = expected_q.pop_front();
            if (got.percent !== exp.percent)
                report("percent", int'(exp.percent), int'(got.percent));
            if (got.mode !== exp.mode) report("mode", int'(exp.mode), int'(got.mode));
            if (got.low_bound !== exp.low_bound)
                report("low_bound", int'(exp.low_bound), int'(got.low_bound));
            if (got.high_bound !== exp.high_bound)
                report("high_bound", int'(exp.high_bound), int'(got.high_bound));
            if (got.calibration_done !== exp.calibration_done)
                report("calibration_done", int'(exp.calibration_done),
                       int'(got.calibration_done));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_t         s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_t        m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_SWING;
    logic [19:0] cfg_data  = '0;

    percent_scoreboard sb = new();

    int items_sent = 0;
    int burst_left = 0;
    int ready_hold = 0;
    int ready_roll;
    int base;
    int swing_t;
    int run_n;

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    gesture_triggered_minmax_normalizer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // result side stalls: long ready stretches, short stalls, now and then a long one
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold--;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 5) begin
                m_ready    <= 1'b1;
                ready_hold = $urandom_range(100, 300);
            end else if (ready_roll < 60) begin
                m_ready    <= 1'b1;
                ready_hold = $urandom_range(0, 8);
            end else if (ready_roll < 95) begin
                m_ready    <= 1'b0;
                ready_hold = $urandom_range(0, 3);
            end else begin
                m_ready    <= 1'b0;
                ready_hold = $urandom_range(10, 40);
            end
        end
    end

    function automatic int idle_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(30, 100);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // values at the extremes, close to the channel's bounds, or anywhere
    function automatic int pick_value(int ch);
        int r;
        int x;
        r = $urandom_range(0, 99);
        if (r < 10) return 0;
        if (r < 20) return 4095;
        if (r < 45) begin
            x = (r < 33 ? sb.lo_b[ch] : sb.hi_b[ch]) + $urandom_range(0, 6) - 3;
            if (x < 0) x = 0;
            if (x > 4095) x = 4095;
            return x;
        end
        return $urandom_range(0, 4095);
    endfunction

    function automatic in_t build(op_t op, int ch, int v, int acc, int sel);
        in_t it;
        it.op           = op;
        it.channel      = ch[3:0];
        it.sample       = v[11:0];
        it.accel        = acc[15:0];
        it.bound_select = sel[0];
        return it;
    endfunction

    function automatic in_t random_item(int ws, int wt, int wa, int wl);
        int  r;
        int  ch;
        int  v;
        op_t op;
        r = $urandom_range(0, ws + wt + wa + wl - 1);
        if (r < ws) op = OP_SAMPLE;
        else if (r < ws + wt) op = OP_TICK;
        else if (r < ws + wt + wa) op = OP_ACCEL;
        else op = OP_LOAD;
        ch = $urandom_range(0, 15);
        if (op == OP_SAMPLE || op == OP_LOAD) v = pick_value(ch);
        else v = $urandom_range(0, 4095);
        return build(op, ch, v, $urandom_range(0, 65535), $urandom_range(0, 1));
    endfunction

    task automatic send(in_t it);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
        items_sent++;
    endtask

    // stop sending until every result is back, then let the back end settle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic cfg_put(cfg_idx_t idx, logic [19:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic program_regs(int thr, int wt, int cl);
        cfg_put(CFG_SWING, 20'(thr));
        cfg_put(CFG_WAIT, 20'(wt));
        cfg_put(CFG_CALIB, 20'(cl));
        cfg_valid <= 1'b0;
    endtask

    // in waiting mode accel stays inside the swing band and ticks stop short of the timeout
    task automatic run_random(int n, int ws, int wt, int wa, int wl, bit waiting);
        in_t it;
        repeat (n) begin
            it = random_item(ws, wt, wa, wl);
            if (waiting) begin
                it.accel = 16'(base + $urandom_range(0, 2 * swing_t) - swing_t);
                if (it.op == OP_TICK && sb.ticks >= sb.wait_limit) it.op = OP_SAMPLE;
            end
            send(it);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        base    = $urandom_range(0, 4000) - 2000;
        swing_t = $urandom_range(350, 3000);

        // bounds still zero, full range, inverted bounds, clamping on both sides
        send(build(OP_SAMPLE, 0, 0, 0, 0));
        send(build(OP_LOAD, 1, 0, 0, 0));
        send(build(OP_LOAD, 1, 4095, 0, 1));
        send(build(OP_SAMPLE, 1, 4095, 0, 0));
        send(build(OP_SAMPLE, 1, 0, 0, 0));
        send(build(OP_SAMPLE, 1, 2048, 0, 0));
        send(build(OP_LOAD, 2, 4095, 0, 0));
        send(build(OP_LOAD, 2, 0, 0, 1));
        send(build(OP_SAMPLE, 2, 0, 0, 0));
        send(build(OP_SAMPLE, 2, 4095, 0, 0));
        send(build(OP_SAMPLE, 2, 2000, 0, 0));
        send(build(OP_LOAD, 3, 1000, 0, 0));
        send(build(OP_LOAD, 3, 2000, 0, 1));
        send(build(OP_SAMPLE, 3, 500, 0, 0));
        send(build(OP_SAMPLE, 3, 3000, 0, 0));
        send(build(OP_SAMPLE, 3, 1999, 0, 0));
        // first accel only sets the baseline; then exactly at the default threshold
        send(build(OP_ACCEL, 4, 0, base, 0));
        send(build(OP_ACCEL, 4, 0, base - int'(SWING_RESET), 0));
        send(build(OP_ACCEL, 4, 0, base + int'(SWING_RESET), 0));
        repeat (3) send(build(OP_TICK, 15, 4095, -1, 1));
        send(build(OP_SAMPLE, 15, $urandom_range(0, 4095), 0, 0));
        drain();

        program_regs(32767, 1048575, 1048575);
        run_random(300, 40, 15, 20, 25, 1);
        drain();

        program_regs(swing_t, sb.ticks + $urandom_range(40, 120), $urandom_range(40, 80));
        run_random(300, 40, 15, 20, 25, 1);
        // tick count equal to the timeout keeps the block waiting
        while (sb.ticks < sb.wait_limit) send(random_item(0, 1, 0, 0));
        send(build(OP_ACCEL, 5, 0, base - swing_t, 0));
        send(build(OP_ACCEL, 5, 0, base + swing_t, 0));
        send(build(OP_ACCEL, 5, 0, base - swing_t - 1, 0));
        send(build(OP_ACCEL, 5, 0, base + swing_t + 1, 0));

        while (sb.mode != MODE_RUN) send(random_item(45, 10, 15, 15));
        drain();

        run_n = (ITEMS - items_sent) / 4;
        if (run_n < 100) run_n = 100;
        program_regs(0, 1, 1);
        run_random(run_n, 50, 10, 15, 25, 0);
        drain();
        program_regs($urandom_range(0, 32767), $urandom_range(1, 1048575),
                     $urandom_range(1, 1048575));
        run_random(run_n, 50, 10, 15, 25, 0);
        drain();
        program_regs($urandom_range(0, 32767), $urandom_range(1, 1048575),
                     $urandom_range(1, 1048575));
        run_random(run_n, 50, 10, 15, 25, 0);
        drain();
        program_regs(int'(SWING_RESET), int'(WAIT_RESET), int'(CALIB_RESET));
        run_random(run_n, 50, 10, 15, 25, 0);
        drain();

        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #(LIMIT);
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/gtmn_pkg.sv
rtl/gtmn_ram.sv
rtl/gtmn_front.sv
rtl/gtmn_fifo.sv
rtl/gtmn_back.sv
rtl/gesture_triggered_minmax_normalizer.sv
dv/testbench.sv
